/* hdl/pkst_pkg.sv */
// Package for the probed key slot table: sizes, types and codes.
`timescale 1ns / 1ps
package pkst_pkg;

  localparam int NUM_SLOTS  = 1024;   // power of two
  localparam int KEY_BITS   = 32;
  localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
  localparam int IDX_BITS   = 10;     // width of the reported slot index

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [SLOT_BITS:0]   count_t;  // holds NUM_SLOTS itself

  localparam key_t KEY_EMPTY = '0;
  localparam key_t KEY_TOMB  = '1;

  typedef struct packed {
    logic active;
    key_t key;
  } entry_t;

  typedef enum logic [1:0] {
    FAIL_NONE     = 2'd0,
    FAIL_FULL     = 2'd1,
    FAIL_RESERVED = 2'd2
  } failure_t;

  typedef struct packed {
    failure_t              failure;
    logic                  fresh;
    logic                  granted;
    logic [IDX_BITS-1:0]   slot_index;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_SWEEP
  } state_t;

endpackage

/* hdl/probed_key_slot_table_unit.sv */
// Probed key slot table: open addressing with triangular probing and tombstones.
`timescale 1ns / 1ps
// Operation: a lookup probes P slots (1 to NUM_SLOTS), one slot a cycle through the single
//   read port of the slot memory; a reserved key is answered without a probe; a sweep
//   visits every slot, one slot a cycle.
// Throughput: one word in flight; the next word is taken once the last one is done and the
//   result register ahead of the output is free. Results then leave through an output stage.
// Reset: synchronous; afterwards a clearing pass writes every slot empty and inactive,
//   and no word is taken during it.
module probed_key_slot_table_unit
  import pkst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[31:0]
  input  logic        s_tuser,   // action: 0 lookup, 1 end-of-frame sweep
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // slot_index[9:0], granted[10], fresh[11], failure[13:12], 0
);

  // Slot memory: active mark and key per slot, one read and one write port
  entry_t mem [NUM_SLOTS];
  entry_t rdata;
  slot_t  rd_addr;
  logic   wr_en;
  slot_t  wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Control and working registers
  state_t  state, state_next;
  count_t  count, count_next;       // clear/sweep address, probe step
  slot_t   cur_slot, cur_slot_next; // slot whose entry is in rdata while probing
  key_t    key_q, key_q_next;
  logic    tomb_seen, tomb_seen_next;
  slot_t   tomb_slot, tomb_slot_next;
  logic    sw_valid, sw_valid_next;  // rdata holds the sweep entry at sw_addr
  slot_t   sw_addr, sw_addr_next;
  result_t res, res_next;
  logic    res_pend, res_set;
  logic    res_move;

  key_t  key_in;
  logic  accept;
  logic  hit, tomb_here, last_probe;
  slot_t pick;

  assign key_in     = key_t'(s_tdata);
  assign s_tready   = (state == ST_IDLE) && !res_pend;
  assign accept     = s_tvalid && s_tready;
  assign hit        = (rdata.key == KEY_EMPTY) || (rdata.key == key_q);
  assign tomb_here  = (rdata.key == KEY_TOMB);
  assign last_probe = (count == count_t'(NUM_SLOTS));
  assign pick       = tomb_here ? cur_slot : tomb_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      count     <= '0;
      tomb_seen <= 1'b0;
      sw_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      tomb_seen <= tomb_seen_next;
      sw_valid  <= sw_valid_next;
    end
    cur_slot  <= cur_slot_next;
    key_q     <= key_q_next;
    tomb_slot <= tomb_slot_next;
    sw_addr   <= sw_addr_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    cur_slot_next  = cur_slot;
    key_q_next     = key_q;
    tomb_seen_next = tomb_seen;
    tomb_slot_next = tomb_slot;
    sw_valid_next  = 1'b0;
    sw_addr_next   = sw_addr;
    res_next       = res;
    res_set        = 1'b0;
    rd_addr        = cur_slot;
    wr_en          = 1'b0;
    wr_addr        = cur_slot;
    wr_data        = '{active: 1'b1, key: key_q};

    unique case (state)
      ST_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = slot_t'(count);
        wr_data    = '0;
        count_next = count + count_t'(1);
        if (count == count_t'(NUM_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        rd_addr = slot_t'(key_in);
        if (accept) begin
          if (s_tuser) begin
            count_next = '0;
            state_next = ST_SWEEP;
          end else if ((key_in == KEY_EMPTY) || (key_in == KEY_TOMB)) begin
            res_next = '{failure: FAIL_RESERVED, fresh: 1'b0, granted: 1'b0, slot_index: '0};
            res_set  = 1'b1;
          end else begin
            key_q_next     = key_in;
            cur_slot_next  = slot_t'(key_in);
            count_next     = count_t'(1);
            tomb_seen_next = 1'b0;
            state_next     = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        if (tomb_here) begin
          tomb_seen_next = 1'b1;
          tomb_slot_next = cur_slot;
        end
        if (hit) begin
          // empty or matching slot ends the probe
          wr_en      = 1'b1;
          wr_addr    = cur_slot;
          res_next   = '{failure: FAIL_NONE, fresh: (rdata.key != key_q), granted: 1'b1,
                         slot_index: IDX_BITS'(cur_slot)};
          res_set    = 1'b1;
          state_next = ST_IDLE;
        end else if (last_probe) begin
          if (tomb_here || tomb_seen) begin
            wr_en    = 1'b1;
            wr_addr  = pick;
            res_next = '{failure: FAIL_NONE, fresh: 1'b1, granted: 1'b1,
                         slot_index: IDX_BITS'(pick)};
          end else begin
            res_next = '{failure: FAIL_FULL, fresh: 1'b0, granted: 1'b0, slot_index: '0};
          end
          res_set    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          rd_addr       = cur_slot + slot_t'(count);
          cur_slot_next = cur_slot + slot_t'(count);
          count_next    = count + count_t'(1);
        end
      end

      ST_SWEEP: begin
        // read slot count, write back slot count-1, read in the previous cycle
        wr_en   = sw_valid;
        wr_addr = sw_addr;
        wr_data = '{active: 1'b0,
                    key: (!rdata.active && (rdata.key != KEY_EMPTY)) ? KEY_TOMB : rdata.key};
        rd_addr = slot_t'(count);
        if (last_probe) begin
          res_next   = '{failure: FAIL_NONE, fresh: 1'b0, granted: 1'b0, slot_index: '0};
          res_set    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          sw_valid_next = 1'b1;
          sw_addr_next  = slot_t'(count);
          count_next    = count + count_t'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result word waits in res until the output stage is free
  assign res_move = res_pend && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_set) begin
        res_pend <= 1'b1;
      end else if (res_move) begin
        res_pend <= 1'b0;
      end
      if (res_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (res_move) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule
